FILE: hdl/utf8s_pkg.sv
// shared types and constants for the utf8 sequence sanitizer
// no dependencies; used by utf8s_core, utf8s_fifo and utf8s_top

package utf8s_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned MAX_RES = 3;

	localparam logic [7:0] QMARK = 8'h3f;
	localparam logic [1:0] CONT_TAG = 2'b10;
	localparam logic [3:0] LEAD2_A = 4'hc;
	localparam logic [3:0] LEAD2_B = 4'hd;
	localparam logic [3:0] LEAD3 = 4'he;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} utf8s_item_t;

	// results of one input item, up to three
	typedef struct packed {
		logic [1:0]             cnt;
		utf8s_item_t [MAX_RES-1:0] items;
	} utf8s_res_t;

endpackage

FILE: hdl/utf8s_if.sv
// valid/ready stream interfaces for the sanitizer input and output bytes
// no dependencies

interface utf8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface utf8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink (input valid, out_byte, out_last, output ready);
endinterface

FILE: hdl/utf8s_core.sv
// sequence tracker: holds lead and continuation bytes, makes up to three results
// depends on utf8s_pkg

module utf8s_core
	import utf8s_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output utf8s_res_t res
);

	logic [1:0] held_q;
	logic       two_q;
	logic [7:0] lead_q;
	logic [7:0] cont_q;

	logic [1:0] nxt_held;
	logic       nxt_two;
	logic [7:0] nxt_lead;
	logic [7:0] nxt_cont;
	logic [1:0] n;
	logic       consumed;
	logic       is_cont;
	utf8s_item_t [MAX_RES-1:0] items;

	assign is_cont = (in_byte[7:6] == CONT_TAG);

	always_comb begin
		items = '0;
		n = 2'd0;
		consumed = 1'b0;
		nxt_held = held_q;
		nxt_two = two_q;
		nxt_lead = lead_q;
		nxt_cont = cont_q;

		if (held_q != 2'd0) begin
			if (is_cont) begin
				consumed = 1'b1;
				if (two_q && held_q == 2'd1) begin
					nxt_cont = in_byte;
					nxt_held = 2'd2;
				end else begin
					items[0] = '{data: lead_q, last: 1'b0};
					n = 2'd1;
					if (held_q == 2'd2) begin
						items[1] = '{data: cont_q, last: 1'b0};
						n = 2'd2;
					end
					items[n] = '{data: in_byte, last: 1'b0};
					n = n + 2'd1;
					nxt_held = 2'd0;
				end
			end else begin
				// broken sequence: every held byte becomes a question mark
				items[0] = '{data: QMARK, last: 1'b0};
				if (held_q == 2'd2)
					items[1] = '{data: QMARK, last: 1'b0};
				n = held_q;
				nxt_held = 2'd0;
			end
		end

		if (!consumed) begin
			case (in_byte[7:4])
				LEAD2_A, LEAD2_B: begin
					nxt_lead = in_byte;
					nxt_two = 1'b0;
					nxt_held = 2'd1;
				end
				LEAD3: begin
					nxt_lead = in_byte;
					nxt_two = 1'b1;
					nxt_held = 2'd1;
				end
				default: begin
					items[n] = '{data: (in_byte[7] ? QMARK : in_byte), last: 1'b0};
					n = n + 2'd1;
				end
			endcase
		end

		if (in_last) begin
			// end of string flushes whatever is still held
			if (nxt_held != 2'd0 && n != 2'd3) begin
				items[n] = '{data: QMARK, last: 1'b0};
				n = n + 2'd1;
			end
			if (nxt_held == 2'd2 && n != 2'd3) begin
				items[n] = '{data: QMARK, last: 1'b0};
				n = n + 2'd1;
			end
			nxt_held = 2'd0;
			if (n != 2'd0)
				items[n - 2'd1].last = 1'b1;
		end

		res.cnt = n;
		res.items = items;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			two_q <= 1'b0;
			lead_q <= 8'h00;
			cont_q <= 8'h00;
		end else if (fire) begin
			held_q <= nxt_held;
			two_q <= nxt_two;
			lead_q <= nxt_lead;
			cont_q <= nxt_cont;
		end
	end

`ifndef SYNTHESIS
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3)
		else $error("held count out of range");
	a_two_held: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == 2'd2 |-> two_q)
		else $error("two bytes held without a three-byte lead");
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_last |=> held_q == 2'd0)
		else $error("bytes still held after end of string");
`endif

endmodule

FILE: hdl/utf8s_fifo.sv
// output queue: takes up to three results at once, hands out one per cycle while tx.ready is high
// depends on utf8s_pkg and utf8s_if

module utf8s_fifo
	import utf8s_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  utf8s_res_t res,
	output logic       room,
	utf8s_out_if.source tx
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	utf8s_item_t      mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             pop;
	logic [CW-1:0]    push_n;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
		logic [PW:0] s;
		s = {1'b0, p} + {{(PW - 1){1'b0}}, k};
		if (s >= (PW + 1)'(DEPTH))
			s = s - (PW + 1)'(DEPTH);
		return s[PW-1:0];
	endfunction

	assign room = (count_q <= CW'(DEPTH - MAX_RES));
	assign pop = tx.valid && tx.ready;
	assign push_n = push ? CW'(res.cnt) : '0;

	assign tx.valid = (count_q != '0);
	assign tx.out_byte = mem_q[rd_q].data;
	assign tx.out_last = mem_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (2'(i) < res.cnt)
					mem_q[wrap_add(wr_q, 2'(i))] <= res.items[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wrap_add(wr_q, res.cnt);
			if (pop)
				rd_q <= wrap_add(rd_q, 2'd1);
			count_q <= count_q + push_n - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("output queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("results pushed without room");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + $past(push_n))
		else $error("queue fill does not follow pushed results");
`endif

endmodule

FILE: hdl/utf8s_top.sv
// utf8 sequence sanitizer top level: input register, sequence tracker, output queue
// an accepted item passes the input register, then the output queue, before its first result reaches the output
// throughput: one item per cycle while the output queue holds at most DEPTH - MAX_RES results (one by default);
// an item waits in its input register until the output queue has room for three
// reset (arst_n, asynchronous, active low) empties the queue and drops any held bytes
// depends on utf8s_pkg, utf8s_if, utf8s_core, utf8s_fifo

module utf8_sequence_sanitizer_top
	import utf8s_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	utf8s_in_if.sink    rx,
	utf8s_out_if.source tx
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       push;
	utf8s_res_t res;

	assign push = v_s1 && room;
	assign rx.ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
			last_s1 <= rx.in_last;
		end
	end

	utf8s_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (push),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (res)
	);

	utf8s_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.room   (room),
		.tx     (tx)
	);

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !room |=> v_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled item lost from input register");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> rx.ready)
		else $error("input refused while input register empty");
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> v_s1)
		else $error("push without a registered item");
`endif

endmodule
